### design/position_lock_window_detector_macros.svh
// Assertion macros for the position lock window detector.
// Used by the top-level RTL file in this folder; no other dependencies.
`ifndef POSITION_LOCK_WINDOW_DETECTOR_MACROS_SVH
`define POSITION_LOCK_WINDOW_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, off while reset is high.
`define PLW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs through reset.
`define PLW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLW_ASSERT(lbl, clk, rst, prop, msg)
`define PLW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/plw_pkg.sv
// Shared types, constants and microcode ROM of the position lock window detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plw_pkg;

  localparam int SampleBits   = 32;
  localparam int AnchorBits   = 8;
  localparam int CountBits    = 4;
  localparam int InDataBits   = 112;
  localparam int OutDataBits  = 8;
  localparam int CfgIndexBits = 1;
  localparam int CfgDataBits  = 32;

  localparam logic [SampleBits-1:0] ThresholdReset  = 32'd16777;
  localparam logic [CountBits-1:0]  MinAnchorsReset = 4'd4;

  // config register indexes
  localparam logic [CfgIndexBits-1:0] RegSpreadThreshold = 1'b0;
  localparam logic [CfgIndexBits-1:0] RegMinAnchors      = 1'b1;

  // sequencer steps
  localparam int StepBits = 3;
  localparam logic [StepBits-1:0] StepIdle  = 3'd0;
  localparam logic [StepBits-1:0] StepCheck = 3'd1;
  localparam logic [StepBits-1:0] StepScan  = 3'd2;
  localparam logic [StepBits-1:0] StepDrain = 3'd3;
  localparam logic [StepBits-1:0] StepEmit  = 3'd4;

  // next-step operations
  localparam logic [1:0] SeqNext       = 2'd0;
  localparam logic [1:0] SeqJump       = 2'd1;
  localparam logic [1:0] SeqJumpIf     = 2'd2;
  localparam logic [1:0] SeqHoldUnless = 2'd3;

  // jump conditions
  localparam logic [1:0] CondInFire   = 2'd0;
  localparam logic [1:0] CondNotFull  = 2'd1;
  localparam logic [1:0] CondScanLast = 2'd2;
  localparam logic [1:0] CondOutFree  = 2'd3;

  typedef struct packed {
    logic                ready;
    logic                clr_acc;
    logic                rd_en;
    logic                emit;
    logic [1:0]          seq_op;
    logic [1:0]          cond;
    logic [StepBits-1:0] target;
  } ctrl_word_t;

  // datapath strobes from the sequencer
  typedef struct packed {
    logic ready;
    logic clr_acc;
    logic rd_en;
    logic emit;
  } ctrl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic in_fire;
    logic not_full;
    logic scan_last;
    logic out_free;
  } stat_t;

  function automatic ctrl_word_t rom_word(input logic [StepBits-1:0] step);
    ctrl_word_t w;
    unique case (step)
      StepIdle:  w = '{ready: 1'b1, clr_acc: 1'b0, rd_en: 1'b0, emit: 1'b0,
                       seq_op: SeqHoldUnless, cond: CondInFire, target: StepCheck};
      StepCheck: w = '{ready: 1'b0, clr_acc: 1'b1, rd_en: 1'b0, emit: 1'b0,
                       seq_op: SeqJumpIf, cond: CondNotFull, target: StepEmit};
      StepScan:  w = '{ready: 1'b0, clr_acc: 1'b0, rd_en: 1'b1, emit: 1'b0,
                       seq_op: SeqHoldUnless, cond: CondScanLast, target: StepDrain};
      StepDrain: w = '{ready: 1'b0, clr_acc: 1'b0, rd_en: 1'b0, emit: 1'b0,
                       seq_op: SeqNext, cond: CondInFire, target: StepEmit};
      StepEmit:  w = '{ready: 1'b0, clr_acc: 1'b0, rd_en: 1'b0, emit: 1'b1,
                       seq_op: SeqHoldUnless, cond: CondOutFree, target: StepIdle};
      default:   w = '{ready: 1'b0, clr_acc: 1'b0, rd_en: 1'b0, emit: 1'b0,
                       seq_op: SeqJump, cond: CondInFire, target: StepIdle};
    endcase
    return w;
  endfunction

  function automatic logic [CountBits-1:0] popcount(input logic [AnchorBits-1:0] m);
    logic [CountBits-1:0] n;
    n = '0;
    for (int i = 0; i < AnchorBits; i++) begin
      n = n + CountBits'(m[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### design/plw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module plw_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 50
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/plw_seq.sv
// Microcoded sequencer: step counter, control ROM and jump logic.
// Depends on plw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plw_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire plw_pkg::stat_t stat,
  output plw_pkg::ctrl_t      ctrl
);

  import plw_pkg::*;

  logic [StepBits-1:0] step;
  logic [StepBits-1:0] step_next;
  ctrl_word_t          word;
  logic                cond_hit;

  assign word = rom_word(step);

  always_comb begin
    unique case (word.cond)
      CondInFire:   cond_hit = stat.in_fire;
      CondNotFull:  cond_hit = stat.not_full;
      CondScanLast: cond_hit = stat.scan_last;
      CondOutFree:  cond_hit = stat.out_free;
    endcase
  end

  always_comb begin
    unique case (word.seq_op)
      SeqNext:       step_next = step + StepBits'(1);
      SeqJump:       step_next = word.target;
      SeqJumpIf:     step_next = cond_hit ? word.target : step + StepBits'(1);
      SeqHoldUnless: step_next = cond_hit ? word.target : step;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= StepIdle;
    end else begin
      step <= step_next;
    end
  end

  // no beat is taken while reset is held
  assign ctrl = '{ready: word.ready && !rst, clr_acc: word.clr_acc,
                  rd_en: word.rd_en, emit: word.emit};

endmodule

`default_nettype wire

### design/plw_dp.sv
// Datapath: sample window RAM, pointers, max/min scan, config registers, result register.
// Depends on plw_pkg and plw_ram.
`timescale 1ns / 1ps
`default_nettype none

module plw_dp #(
  parameter int WINDOW_DEPTH = 50
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire plw_pkg::ctrl_t                      ctrl,
  output plw_pkg::stat_t                           stat,
  input  wire logic                                cfg_we,
  input  wire logic [plw_pkg::CfgIndexBits-1:0]    cfg_index,
  input  wire logic [plw_pkg::CfgDataBits-1:0]     cfg_data,
  input  wire logic                                s_axis_tvalid,
  input  wire logic [plw_pkg::InDataBits-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [plw_pkg::OutDataBits-1:0]     m_axis_tdata
);

  import plw_pkg::*;

  localparam int AddrBits = $clog2(WINDOW_DEPTH);
  localparam int FillBits = $clog2(WINDOW_DEPTH + 1);
  localparam int RowBits  = 3 * SampleBits;
  localparam logic [AddrBits-1:0] LastAddr  = AddrBits'(WINDOW_DEPTH - 1);
  localparam logic [FillBits-1:0] FullCount = FillBits'(WINDOW_DEPTH);

  logic                  in_fire;
  logic                  out_free;
  logic [AddrBits-1:0]   wr_ptr;
  logic [FillBits-1:0]   fill;
  logic [AddrBits-1:0]   scan_addr;
  logic                  rd_valid;
  logic [RowBits-1:0]    row_rd;
  logic [SampleBits-1:0] rd_x, rd_y, rd_z;
  logic [SampleBits-1:0] max_x, max_y, max_z;
  logic [SampleBits-1:0] min_x, min_y, min_z;
  logic [SampleBits-1:0] spread_threshold;
  logic [CountBits-1:0]  min_anchors;
  logic [CountBits-1:0]  anchors;
  logic                  calib;
  logic                  full;
  logic                  lock;

  assign in_fire  = ctrl.ready && s_axis_tvalid;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign full     = (fill == FullCount);

  assign stat = '{in_fire: in_fire, not_full: !full,
                  scan_last: (scan_addr == LastAddr), out_free: out_free};

  // one row holds x, y, z of a sample
  plw_ram #(
    .WIDTH(RowBits),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (in_fire),
    .waddr(wr_ptr),
    .wdata(s_axis_tdata[RowBits-1:0]),
    .re   (ctrl.rd_en),
    .raddr(scan_addr),
    .rdata(row_rd)
  );

  assign rd_x = row_rd[0 +: SampleBits];
  assign rd_y = row_rd[SampleBits +: SampleBits];
  assign rd_z = row_rd[2*SampleBits +: SampleBits];

  assign lock = full
             && ((max_x - min_x) < spread_threshold)
             && ((max_y - min_y) < spread_threshold)
             && ((max_z - min_z) < spread_threshold)
             && calib
             && (anchors >= min_anchors);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr           <= '0;
      fill             <= '0;
      rd_valid         <= 1'b0;
      m_axis_tvalid    <= 1'b0;
      spread_threshold <= ThresholdReset;
      min_anchors      <= MinAnchorsReset;
    end else begin
      rd_valid <= ctrl.rd_en;
      if (in_fire) begin
        wr_ptr <= (wr_ptr == LastAddr) ? '0 : wr_ptr + AddrBits'(1);
        if (!full) begin
          fill <= fill + FillBits'(1);
        end
      end
      if (ctrl.emit && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          RegSpreadThreshold: spread_threshold <= cfg_data[SampleBits-1:0];
          RegMinAnchors:      min_anchors      <= cfg_data[CountBits-1:0];
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      anchors <= popcount(s_axis_tdata[RowBits +: AnchorBits]);
      calib   <= s_axis_tdata[RowBits + AnchorBits];
    end
    if (ctrl.clr_acc) begin
      scan_addr <= '0;
      max_x <= '0;
      max_y <= '0;
      max_z <= '0;
      min_x <= '1;
      min_y <= '1;
      min_z <= '1;
    end else begin
      if (ctrl.rd_en) begin
        scan_addr <= scan_addr + AddrBits'(1);
      end
      if (rd_valid) begin
        if (rd_x > max_x) max_x <= rd_x;
        if (rd_y > max_y) max_y <= rd_y;
        if (rd_z > max_z) max_z <= rd_z;
        if (rd_x < min_x) min_x <= rd_x;
        if (rd_y < min_y) min_y <= rd_y;
        if (rd_z < min_z) min_z <= rd_z;
      end
    end
    if (ctrl.emit && out_free) begin
      m_axis_tdata <= {2'b00, full, anchors, lock};
    end
  end

endmodule

`default_nettype wire

### design/position_lock_window_detector.sv
// Top level of the position lock window detector: sequencer plus datapath.
// Depends on plw_pkg, plw_seq, plw_dp (and plw_ram below it), and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

// Position lock window detector. Each input beat carries x/y/z position variances
// (unsigned Q8.24), an 8-bit anchor mask and a sensors-calibrated flag; each input
// beat yields exactly one output beat with locked, anchors_seen and window_full.
// Samples are stored in a WINDOW_DEPTH-deep ring (one RAM row holds x, y and z);
// a fill count tracks how many rows are valid, so no clearing pass is needed after
// reset. Once the window is full, every item triggers a scan of all rows through
// the RAM's single read port, one row per cycle, collecting max and min per axis.
// Lock = window full, every axis spread (max - min) strictly below spread_threshold,
// calibrated set, and popcount(anchor_mask) >= min_anchors.
// Steps: while the window is filling, an item passes the idle, check and result
// steps; once full it passes idle, check, a scan of all rows, a drain step and the
// result step, at which the result register loads. One item is in flight at a
// time; a new beat is accepted while the previous result still waits in the output
// register, and the block stalls at the result step only if that register is still
// occupied. Ready stays low while reset is held.
// Config writes (cfg_we/cfg_index/cfg_data) take effect at once; write them only
// while idle. Index 0: spread_threshold, index 1: min_anchors (low 4 bits).

`include "position_lock_window_detector_macros.svh"

module position_lock_window_detector #(
  parameter int WINDOW_DEPTH = 50
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // config write port
  input  wire logic                             cfg_we,
  input  wire logic [plw_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [plw_pkg::CfgDataBits-1:0]  cfg_data,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] var_x, [63:32] var_y, [95:64] var_z, [103:96] anchor_mask,
  // [104] calibrated, [111:105] zero
  input  wire logic [plw_pkg::InDataBits-1:0]   s_axis_tdata,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [0] locked, [4:1] anchors_seen, [5] window_full, [7:6] zero
  output logic      [plw_pkg::OutDataBits-1:0]  m_axis_tdata
);

  import plw_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  plw_seq u_seq (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .ctrl(ctrl)
  );

  plw_dp #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // ready only in the idle step
  assign s_axis_tready = ctrl.ready;

  // one item in flight: ready drops right after a beat is taken
  `PLW_ASSERT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready held after accept")
  // a result only appears after the result step
  `PLW_ASSERT(a_result_from_emit, clk, rst, $rose(m_axis_tvalid) |-> $past(ctrl.emit), "result without emit step")
  // lock implies a full window
  `PLW_ASSERT(a_lock_needs_full, clk, rst, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[5], "locked with window not full")
  // reset empties the result register
  `PLW_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_axis_tvalid, "result valid after reset")

endmodule

`default_nettype wire
